/* rtl/core/esd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

  localparam int MAX_RESULTS = 5;
  localparam int COUNT_W     = 3;

  localparam logic [2:0] ERR_NONE           = 3'd0;
  localparam logic [2:0] ERR_LONE_BACKSLASH = 3'd1;
  localparam logic [2:0] ERR_BAD_HEX        = 3'd2;
  localparam logic [2:0] ERR_SHORT_UNICODE  = 3'd3;
  localparam logic [2:0] ERR_UNICODE_RANGE  = 3'd4;
  localparam logic [2:0] ERR_SURROGATE      = 3'd5;

  localparam logic [31:0] UNICODE_MAX   = 32'h0010_FFFF;
  localparam logic [4:0]  SURROGATE_TAG = 5'b11011;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_end;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_terminator;
    logic [2:0] error_code;
    logic       run_last;
  } out_req_t;

  // Results caused by one input byte, in order.
  typedef struct packed {
    logic [COUNT_W-1:0]              count;
    out_req_t [MAX_RESULTS-1:0]      slot;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/core/escape_sequence_decoder_core.sv */
// channel   dir  handshake            payload
// in        in   in_valid/in_ready    in_req  (in_byte, string_end)
// out       out  out_valid/out_ready  out_req (out_byte, is_terminator, error_code, run_last)
// cfg       in   cfg_valid/cfg_ready  cfg_data (unicode_escapes_enabled)
//
// One byte accepted per cycle while the command queue has room; the decoder
// state updates in the same cycle.
// Each byte yields 0..5 results, sent one per cycle from the output register while
// out_ready is high, so a byte holds the result side until its last result is sent.
// Up to QUEUE_DEPTH decoded bytes wait between the two sides; in_ready drops
// only when that queue is full. cfg_ready is always high.
// rst (sync): decoder state, queue and output valid cleared, unicode escapes on.
`timescale 1ns / 1ps
`default_nettype none

module escape_sequence_decoder_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire esd_pkg::in_req_t in_req,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output esd_pkg::out_req_t     out_req,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_data
);

  logic          q_full;
  logic          q_push;
  esd_pkg::cmd_t q_cmd;
  logic          head_valid;
  esd_pkg::cmd_t head_cmd;
  logic          q_pop;

  esd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  esd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (q_pop)
  );

  esd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_req    (out_req)
  );

endmodule

`default_nettype wire

/* rtl/core/esd_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module esd_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire esd_pkg::in_req_t in_req,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic            cfg_data,
  input  wire logic            q_full,
  output logic                 q_push,
  output esd_pkg::cmd_t        q_cmd
);

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_ESCAPE,
    MODE_HEX,
    MODE_OCTAL,
    MODE_UNICODE,
    MODE_SKIP
  } mode_t;

  mode_t       mode, mode_next;
  logic [31:0] pending, pending_next;
  logic [3:0]  digits, digits_next;
  logic        long_form, long_form_next;
  logic        uni_en;

  logic [7:0]  c;
  logic [4:0]  hx;
  logic        redo;
  logic [2:0]  n;
  logic [20:0] cp;
  esd_pkg::out_req_t [esd_pkg::MAX_RESULTS-1:0] slots;

  function automatic esd_pkg::out_req_t mk(input logic [7:0] b, input logic term,
                                           input logic [2:0] err);
    esd_pkg::out_req_t r;
    r.out_byte      = b;
    r.is_terminator = term;
    r.error_code    = err;
    r.run_last      = 1'b0;
    return r;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'd0;
    if (ch >= "0" && ch <= "9") begin
      r = {1'b1, 4'(ch - "0")};
    end else if (ch >= "a" && ch <= "f") begin
      r = {1'b1, 4'(ch - "a" + 8'd10)};
    end else if (ch >= "A" && ch <= "F") begin
      r = {1'b1, 4'(ch - "A" + 8'd10)};
    end
    return r;
  endfunction

  assign c         = in_req.in_byte;
  assign hx        = hex_digit(c);
  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;

  always_comb begin
    mode_next      = mode;
    pending_next   = pending;
    digits_next    = digits;
    long_form_next = long_form;
    redo           = 1'b0;
    n              = '0;
    slots          = '0;
    cp             = '0;

    unique case (mode)
      MODE_NORMAL: begin
        redo = 1'b1;
      end
      MODE_ESCAPE: begin
        mode_next    = MODE_NORMAL;
        pending_next = '0;
        digits_next  = '0;
        unique case (c)
          "n": begin slots[n] = mk(8'h0A, 1'b0, esd_pkg::ERR_NONE); n = n + 3'd1; end
          "r": begin slots[n] = mk(8'h0D, 1'b0, esd_pkg::ERR_NONE); n = n + 3'd1; end
          "t": begin slots[n] = mk(8'h09, 1'b0, esd_pkg::ERR_NONE); n = n + 3'd1; end
          "b": begin slots[n] = mk(8'h08, 1'b0, esd_pkg::ERR_NONE); n = n + 3'd1; end
          "f": begin slots[n] = mk(8'h0C, 1'b0, esd_pkg::ERR_NONE); n = n + 3'd1; end
          "a": begin slots[n] = mk(8'h07, 1'b0, esd_pkg::ERR_NONE); n = n + 3'd1; end
          "v": begin slots[n] = mk(8'h0B, 1'b0, esd_pkg::ERR_NONE); n = n + 3'd1; end
          "x": begin
            mode_next = MODE_HEX;
          end
          "0", "1", "2": begin
            mode_next    = MODE_OCTAL;
            pending_next = {30'd0, c[1:0]};
          end
          "u", "U": begin
            if (uni_en) begin
              mode_next      = MODE_UNICODE;
              long_form_next = (c == "U");
            end else begin
              slots[n] = mk(c, 1'b0, esd_pkg::ERR_NONE);
              n = n + 3'd1;
            end
          end
          default: begin
            slots[n] = mk(c, 1'b0, esd_pkg::ERR_NONE);
            n = n + 3'd1;
          end
        endcase
      end
      MODE_HEX: begin
        if (hx[4]) begin
          pending_next = {pending[27:0], hx[3:0]};
          digits_next  = digits + 4'd1;
          if (digits_next >= 4'd2) begin
            slots[n] = mk(pending_next[7:0], 1'b0, esd_pkg::ERR_NONE);
            n = n + 3'd1;
            mode_next = MODE_NORMAL;
          end
        end else if (digits == 4'd0) begin
          slots[n] = mk(8'h00, 1'b0, esd_pkg::ERR_BAD_HEX);
          n = n + 3'd1;
          mode_next = MODE_SKIP;
        end else begin
          slots[n] = mk(pending[7:0], 1'b0, esd_pkg::ERR_NONE);
          n = n + 3'd1;
          mode_next = MODE_NORMAL;
          redo = 1'b1;
        end
      end
      MODE_OCTAL: begin
        if (c[7:3] == 5'b00110) begin
          pending_next = {pending[28:0], c[2:0]};
          digits_next  = digits + 4'd1;
          if (digits_next >= 4'd2) begin
            slots[n] = mk(pending_next[7:0], 1'b0, esd_pkg::ERR_NONE);
            n = n + 3'd1;
            mode_next = MODE_NORMAL;
          end
        end else begin
          slots[n] = mk(pending[7:0], 1'b0, esd_pkg::ERR_NONE);
          n = n + 3'd1;
          mode_next = MODE_NORMAL;
          redo = 1'b1;
        end
      end
      MODE_UNICODE: begin
        if (!hx[4]) begin
          slots[n] = mk(8'h00, 1'b0, esd_pkg::ERR_SHORT_UNICODE);
          n = n + 3'd1;
          mode_next = MODE_SKIP;
        end else begin
          pending_next = {pending[27:0], hx[3:0]};
          digits_next  = digits + 4'd1;
          if (digits_next >= (long_form ? 4'd8 : 4'd4)) begin
            if (pending_next > esd_pkg::UNICODE_MAX) begin
              slots[n] = mk(8'h00, 1'b0, esd_pkg::ERR_UNICODE_RANGE);
              n = n + 3'd1;
              mode_next = MODE_SKIP;
            end else if (pending_next[15:11] == esd_pkg::SURROGATE_TAG) begin
              slots[n] = mk(8'h00, 1'b0, esd_pkg::ERR_SURROGATE);
              n = n + 3'd1;
              mode_next = MODE_SKIP;
            end else begin
              mode_next = MODE_NORMAL;
              cp = pending_next[20:0];
              if (cp < 21'h80) begin
                slots[n] = mk(cp[7:0], 1'b0, esd_pkg::ERR_NONE); n = n + 3'd1;
              end else if (cp < 21'h800) begin
                slots[n] = mk({3'b110, cp[10:6]}, 1'b0, esd_pkg::ERR_NONE); n = n + 3'd1;
                slots[n] = mk({2'b10, cp[5:0]}, 1'b0, esd_pkg::ERR_NONE);   n = n + 3'd1;
              end else if (cp < 21'h10000) begin
                slots[n] = mk({4'b1110, cp[15:12]}, 1'b0, esd_pkg::ERR_NONE); n = n + 3'd1;
                slots[n] = mk({2'b10, cp[11:6]}, 1'b0, esd_pkg::ERR_NONE);    n = n + 3'd1;
                slots[n] = mk({2'b10, cp[5:0]}, 1'b0, esd_pkg::ERR_NONE);     n = n + 3'd1;
              end else begin
                slots[n] = mk({5'b11110, cp[20:18]}, 1'b0, esd_pkg::ERR_NONE); n = n + 3'd1;
                slots[n] = mk({2'b10, cp[17:12]}, 1'b0, esd_pkg::ERR_NONE);    n = n + 3'd1;
                slots[n] = mk({2'b10, cp[11:6]}, 1'b0, esd_pkg::ERR_NONE);     n = n + 3'd1;
                slots[n] = mk({2'b10, cp[5:0]}, 1'b0, esd_pkg::ERR_NONE);      n = n + 3'd1;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase

    // plain text, also the byte that ended a hex or octal run
    if (redo) begin
      if (c == "\\") begin
        mode_next = MODE_ESCAPE;
      end else begin
        slots[n] = mk(c, 1'b0, esd_pkg::ERR_NONE);
        n = n + 3'd1;
      end
    end

    if (in_req.string_end) begin
      unique case (mode_next)
        MODE_ESCAPE: begin
          slots[n] = mk(8'h00, 1'b0, esd_pkg::ERR_LONE_BACKSLASH);
          n = n + 3'd1;
        end
        MODE_HEX: begin
          if (digits_next == 4'd0) begin
            slots[n] = mk(8'h00, 1'b0, esd_pkg::ERR_BAD_HEX);
          end else begin
            slots[n] = mk(pending_next[7:0], 1'b0, esd_pkg::ERR_NONE);
          end
          n = n + 3'd1;
        end
        MODE_OCTAL: begin
          slots[n] = mk(pending_next[7:0], 1'b0, esd_pkg::ERR_NONE);
          n = n + 3'd1;
        end
        MODE_UNICODE: begin
          slots[n] = mk(8'h00, 1'b0, esd_pkg::ERR_SHORT_UNICODE);
          n = n + 3'd1;
        end
        default: begin
        end
      endcase
      slots[n] = mk(8'h00, 1'b1, esd_pkg::ERR_NONE);
      n = n + 3'd1;
      mode_next      = MODE_NORMAL;
      pending_next   = '0;
      digits_next    = '0;
      long_form_next = 1'b0;
    end

    if (n != 3'd0) begin
      slots[n - 3'd1].run_last = 1'b1;
    end
  end

  assign q_push      = in_valid && in_ready && (n != 3'd0);
  assign q_cmd.count = n;
  assign q_cmd.slot  = slots;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_NORMAL;
      pending   <= '0;
      digits    <= '0;
      long_form <= 1'b0;
      uni_en    <= 1'b1;
    end else begin
      if (in_valid && in_ready) begin
        mode      <= mode_next;
        pending   <= pending_next;
        digits    <= digits_next;
        long_form <= long_form_next;
      end
      if (cfg_valid) begin
        uni_en <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/esd_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module esd_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire esd_pkg::cmd_t push_cmd,
  output logic               full,
  output logic               head_valid,
  output esd_pkg::cmd_t      head_cmd,
  input  wire logic          pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  esd_pkg::cmd_t entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] cnt;
  logic          do_push, do_pop;

  assign full       = (cnt == CW'(DEPTH));
  assign head_valid = (cnt != '0);
  assign head_cmd   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/esd_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module esd_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          head_valid,
  input  wire esd_pkg::cmd_t head_cmd,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output esd_pkg::out_req_t  out_req
);

  logic [esd_pkg::COUNT_W-1:0] idx;
  logic                        load;
  logic                        at_last;

  assign load    = !out_valid || out_ready;
  assign at_last = (idx == head_cmd.count - esd_pkg::COUNT_W'(1));
  assign pop     = load && head_valid && at_last;

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_req <= head_cmd.slot[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        idx <= at_last ? '0 : idx + esd_pkg::COUNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/esd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module esd_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire esd_pkg::in_req_t  in_req,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire esd_pkg::out_req_t out_req,
  input wire logic              cfg_valid,
  input wire logic              cfg_ready,
  input wire logic              cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_req))
    else $error("output request changed while stalled");

  a_term_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_req.is_terminator |->
      out_req.run_last && out_req.out_byte == 8'h00 &&
      out_req.error_code == esd_pkg::ERR_NONE)
    else $error("malformed terminator");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_req.error_code != esd_pkg::ERR_NONE |->
      out_req.out_byte == 8'h00 && !out_req.is_terminator &&
      out_req.error_code <= esd_pkg::ERR_SURROGATE)
    else $error("malformed error result");

  a_reset_idle: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind escape_sequence_decoder_core esd_checker u_esd_checker (.*);

`default_nettype wire

/* dv/escape_decoder_checker.sv */
`timescale 1ns / 1ps

module escape_decoder_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  esd_pkg::in_req_t  in_req,
  input  logic              out_valid,
  input  logic              out_ready,
  input  esd_pkg::out_req_t out_req,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic              cfg_data,
  output int                fail_count,
  output int                outstanding
);
  import esd_pkg::*;

  localparam logic [7:0] BSLASH = 8'h5C;

  typedef enum logic [2:0] {ST_TEXT, ST_ESC, ST_HEX, ST_OCT, ST_UNI, ST_SKIP} dec_state_e;

  dec_state_e  state;
  logic [31:0] acc;
  logic [3:0]  ndig;
  logic        long_form;
  logic        uni_en;
  out_req_t    step_q[$];
  out_req_t    decoded_q[$];
  out_req_t    want;

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  task automatic emit(input logic [7:0] b, input logic term, input logic [2:0] err);
    out_req_t r;
    r.out_byte      = b;
    r.is_terminator = term;
    r.error_code    = err;
    r.run_last      = 1'b0;
    step_q.push_back(r);
  endtask

  task automatic raise(input logic [2:0] err);
    emit(8'h00, 1'b0, err);
    state = ST_SKIP;
  endtask

  task automatic decode_byte(input logic [7:0] c, input logic last);
    out_req_t r;
    int       h;
    bit       again;
    step_q.delete();
    h = hex_nibble(c);
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (state)
        ST_TEXT: begin
          if (c == BSLASH) state = ST_ESC;
          else emit(c, 1'b0, ERR_NONE);
        end
        ST_ESC: begin
          state = ST_TEXT;
          acc   = '0;
          ndig  = '0;
          case (c)
            "n": emit(8'h0A, 1'b0, ERR_NONE);
            "r": emit(8'h0D, 1'b0, ERR_NONE);
            "t": emit(8'h09, 1'b0, ERR_NONE);
            "b": emit(8'h08, 1'b0, ERR_NONE);
            "f": emit(8'h0C, 1'b0, ERR_NONE);
            "a": emit(8'h07, 1'b0, ERR_NONE);
            "v": emit(8'h0B, 1'b0, ERR_NONE);
            "x": state = ST_HEX;
            "0", "1", "2": begin
              state = ST_OCT;
              acc   = {30'd0, c[1:0]};
            end
            "u", "U": begin
              if (uni_en) begin
                state     = ST_UNI;
                long_form = (c == "U");
              end else begin
                emit(c, 1'b0, ERR_NONE);
              end
            end
            default: emit(c, 1'b0, ERR_NONE);
          endcase
        end
        ST_HEX: begin
          if (h >= 0) begin
            acc = {acc[27:0], h[3:0]};
            ndig++;
            if (ndig >= 4'd2) begin
              emit(acc[7:0], 1'b0, ERR_NONE);
              state = ST_TEXT;
            end
          end else if (ndig == 4'd0) begin
            raise(ERR_BAD_HEX);
          end else begin
            // digits stop early: flush, then treat byte as text
            emit(acc[7:0], 1'b0, ERR_NONE);
            state = ST_TEXT;
            again = 1'b1;
          end
        end
        ST_OCT: begin
          if (c >= "0" && c <= "7") begin
            acc = {acc[28:0], c[2:0]};
            ndig++;
            if (ndig >= 4'd2) begin
              emit(acc[7:0], 1'b0, ERR_NONE);
              state = ST_TEXT;
            end
          end else begin
            emit(acc[7:0], 1'b0, ERR_NONE);
            state = ST_TEXT;
            again = 1'b1;
          end
        end
        ST_UNI: begin
          if (h < 0) begin
            raise(ERR_SHORT_UNICODE);
          end else begin
            acc = {acc[27:0], h[3:0]};
            ndig++;
            if (ndig >= (long_form ? 4'd8 : 4'd4)) begin
              if (acc > UNICODE_MAX) begin
                raise(ERR_UNICODE_RANGE);
              end else if (acc[15:11] == SURROGATE_TAG) begin
                raise(ERR_SURROGATE);
              end else begin
                if (acc < 32'h80) begin
                  emit(acc[7:0], 1'b0, ERR_NONE);
                end else if (acc < 32'h800) begin
                  emit({3'b110, acc[10:6]}, 1'b0, ERR_NONE);
                  emit({2'b10, acc[5:0]}, 1'b0, ERR_NONE);
                end else if (acc < 32'h10000) begin
                  emit({4'b1110, acc[15:12]}, 1'b0, ERR_NONE);
                  emit({2'b10, acc[11:6]}, 1'b0, ERR_NONE);
                  emit({2'b10, acc[5:0]}, 1'b0, ERR_NONE);
                end else begin
                  emit({5'b11110, acc[20:18]}, 1'b0, ERR_NONE);
                  emit({2'b10, acc[17:12]}, 1'b0, ERR_NONE);
                  emit({2'b10, acc[11:6]}, 1'b0, ERR_NONE);
                  emit({2'b10, acc[5:0]}, 1'b0, ERR_NONE);
                end
                state = ST_TEXT;
              end
            end
          end
        end
        default: ;
      endcase
    end

    if (last) begin
      case (state)
        ST_ESC: raise(ERR_LONE_BACKSLASH);
        ST_HEX: begin
          if (ndig == 4'd0) raise(ERR_BAD_HEX);
          else emit(acc[7:0], 1'b0, ERR_NONE);
        end
        ST_OCT: emit(acc[7:0], 1'b0, ERR_NONE);
        ST_UNI: raise(ERR_SHORT_UNICODE);
        default: ;
      endcase
      emit(8'h00, 1'b1, ERR_NONE);
      state     = ST_TEXT;
      acc       = '0;
      ndig      = '0;
      long_form = 1'b0;
    end

    for (int i = 0; i < step_q.size(); i++) begin
      r = step_q[i];
      r.run_last = (i == step_q.size() - 1);
      decoded_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      state     = ST_TEXT;
      acc       = '0;
      ndig      = '0;
      long_form = 1'b0;
      uni_en    = 1'b1;
      decoded_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected request: out_byte %0h is_terminator %0b error_code %0d",
                 out_req.out_byte, out_req.is_terminator, out_req.error_code);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          if (out_req.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, out_req.out_byte);
            fail_count++;
          end
          if (out_req.is_terminator !== want.is_terminator) begin
            $error("is_terminator: expected %0b, got %0b",
                   want.is_terminator, out_req.is_terminator);
            fail_count++;
          end
          if (out_req.error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, out_req.error_code);
            fail_count++;
          end
          if (out_req.run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, out_req.run_last);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) uni_en = cfg_data;
      if (in_valid && in_ready) decode_byte(in_req.in_byte, in_req.string_end);
    end
    outstanding = decoded_q.size();
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import esd_pkg::*;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_req_t    in_req    = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_req_t   out_req;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data  = 1'b0;
  int         fail_count;
  int         outstanding;
  bit         idle_on   = 1'b1;
  bit         long_hold = 1'b0;
  int         sent      = 0;
  logic [7:0] str_q[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  escape_sequence_decoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_req   (out_req),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  escape_decoder_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_req     (out_req),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 8);
        repeat (gap) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + n;
    return ($urandom_range(0, 1) ? "a" : "A") + (n - 4'd10);
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic last);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= '{in_byte: c, string_end: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_string();
    for (int i = 0; i < str_q.size(); i++) send_byte(str_q[i], i == str_q.size() - 1);
    str_q.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) str_q.push_back(s[i]);
  endtask

  task automatic push_digits(input logic [31:0] v, input int nd);
    for (int i = nd - 1; i >= 0; i--) str_q.push_back(hex_char(v[4*i +: 4]));
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_cfg(input logic en);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= en;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random bytes and mostly well-formed escapes with random content, some broken ones
  task automatic build_random_string();
    string       letters;
    string       junk;
    int          ntok;
    int          kind;
    int          nd;
    logic [31:0] v;
    letters = "nrtbfav'\"?\\";
    junk    = "gZz.-~ ";
    ntok    = $urandom_range(1, 6);
    for (int t = 0; t < ntok; t++) begin
      kind = $urandom_range(0, 19);
      if (kind <= 5) begin
        str_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind <= 7) begin
        push_text("\\");
        str_q.push_back(letters[$urandom_range(0, letters.len() - 1)]);
      end else if (kind <= 9) begin
        push_text("\\x");
        push_digits($urandom, $urandom_range(1, 2));
      end else if (kind <= 11) begin
        push_text("\\");
        str_q.push_back(8'("0" + $urandom_range(0, 2)));
        nd = $urandom_range(0, 2);
        repeat (nd) str_q.push_back(8'("0" + $urandom_range(0, 7)));
      end else if (kind <= 13) begin
        push_text("\\u");
        push_digits($urandom_range(0, 16'hFFFF), 4);
      end else if (kind <= 15) begin
        push_text("\\U");
        v = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h10FFFF);
        push_digits(v, 8);
      end else if (kind == 16) begin
        push_text($urandom_range(0, 1) ? "\\u" : "\\U");
        push_digits($urandom, $urandom_range(0, 3));
        str_q.push_back(junk[$urandom_range(0, junk.len() - 1)]);
      end else if (kind == 17) begin
        push_text("\\x");
        str_q.push_back(junk[$urandom_range(0, junk.len() - 1)]);
      end else if (kind == 18) begin
        push_text("\\");
        str_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        push_text("\\");
      end
    end
  endtask

  task automatic run_phase(input logic en, input int count, input bit hold);
    int start;
    write_cfg(en);
    if (hold) long_hold = 1'b1;
    start = sent;
    while (sent - start < count) begin
      build_random_string();
      send_string();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_cfg(1'b1);
    push_text("\\x4G\\12");
    send_string();
    push_text("\\xZq");
    send_string();
    push_text("\\uD800");
    send_string();
    push_text("\\u12");
    send_string();
    push_text("\\");
    send_string();
    str_q.push_back(8'h00);
    push_text("\\x0");
    str_q.push_back(8'hFF);
    send_string();

    run_phase(1'b0, 55, 1'b1);
    run_phase(1'b1, 55, 1'b0);
    run_phase(1'b0, 55, 1'b0);
    idle_on = 1'b0;
    run_phase(1'b1, 55, 1'b0);

    wait_drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
